### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off while reset is low.
`define TVI_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Concurrent assertion that also runs while reset is low.
`define TVI_ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### hdl/tvi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_pkg
// Types, widths, codes and helpers of the tricubic volume interpolator.
// ----------------------------------------------------------------------------
package tvi_pkg;

  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;
  localparam int MAX_DEPTH_DEF  = 32;

  // index math width, covers bounds up to 511
  localparam int IDX_FW   = 9;

  localparam int VOX_W    = 16;
  localparam int VIDX_W   = 15;
  localparam int CRD_W    = 15;
  localparam int DIMREG_W = 6;
  localparam int KA_W     = 15;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 15;
  localparam int OUT_W    = 24;

  // kernel weight, Q16 signed
  localparam int WT_W     = 20;
  localparam int T_W      = 10;
  localparam int KTAG_W   = 4;

  // accumulator widths
  localparam int PR_W     = 36;
  localparam int XS_W     = 38;
  localparam int YP_W     = 40;
  localparam int YS_W     = 60;
  localparam int PL_W     = 40;
  localparam int ZP_W     = 42;
  localparam int TS_W     = 62;
  localparam int RES_W    = 38;

  localparam logic [DIMREG_W-1:0]    DIM_RST = 6'd32;
  localparam logic signed [KA_W-1:0] KA_RST  = -15'sd2048;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_VOL_WIDTH  = 2'd0,
    CFG_VOL_HEIGHT = 2'd1,
    CFG_VOL_DEPTH  = 2'd2,
    CFG_KERNEL_A   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              vld;
    logic [KTAG_W-1:0] tag;
    logic [T_W-1:0]    t;
  } kin_t;

  typedef struct packed {
    logic                   vld;
    logic [KTAG_W-1:0]      tag;
    logic signed [WT_W-1:0] weight;
  } kout_t;

  // register value limited to 1..mx
  function automatic logic [IDX_FW-1:0] eff_dim(input logic [DIMREG_W-1:0] r,
                                                input logic [IDX_FW-1:0]   mx);
    logic [IDX_FW-1:0] rv;
    rv = IDX_FW'(r);
    if (rv == '0) begin
      return IDX_FW'(1);
    end else if (rv > mx) begin
      return mx;
    end
    return rv;
  endfunction

  // clamp a signed index into 0..hi
  function automatic logic [IDX_FW-1:0] clamp_idx(input logic signed [IDX_FW:0] raw,
                                                  input logic [IDX_FW-1:0]     hi);
    if (raw < 0) begin
      return '0;
    end else if (raw > $signed({1'b0, hi})) begin
      return hi;
    end
    return raw[IDX_FW-1:0];
  endfunction

endpackage

### hdl/tvi_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi channels
// Valid/ready channels of the interpolator: items in, results out, config.
// ----------------------------------------------------------------------------
interface tvi_in_if;
  import tvi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [VIDX_W-1:0]       voxel_index;
  logic signed [VOX_W-1:0] voxel_value;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;
  modport source (output valid, cmd, voxel_index, voxel_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, cmd, voxel_index, voxel_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface tvi_out_if;
  import tvi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] interp_value;
  logic                    saturated;
  modport source (output valid, interp_value, saturated, input ready);
  modport sink   (input valid, interp_value, saturated, output ready);
endinterface

interface tvi_cfg_if;
  import tvi_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/tvi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module tvi_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/tvi_kernel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_kernel
// Pipelined Keys cubic weight: Horner form in Q36, rounded to Q16.
// ----------------------------------------------------------------------------
module tvi_kernel (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [tvi_pkg::KA_W-1:0]  kernel_a,
  input  tvi_pkg::kin_t                    kin,
  output tvi_pkg::kout_t                   kout
);
  import tvi_pkg::*;

  localparam int S1_W = 29;
  localparam int S2_W = 41;
  localparam int S3_W = 53;

  logic signed [16:0]     a17;
  logic signed [T_W:0]    t0s;
  logic                   near0;
  logic signed [16:0]     p0;
  logic signed [26:0]     q0;

  logic                   v1_r, v2_r, v3_r;
  logic [KTAG_W-1:0]      tag1_r, tag2_r, tag3_r;
  logic [T_W-1:0]         t1_r, t2_r;
  logic                   near1_r, near2_r;
  logic signed [S1_W-1:0] s1_r;
  logic signed [S2_W-1:0] s2_r;
  logic signed [S3_W-1:0] s3_r;
  logic signed [S2_W-1:0] r1;
  logic signed [S3_W-1:0] c2;
  kout_t                  kout_r;

  // inner segment |t| <= 1, outer segment 1 < |t| <= 2
  assign a17   = 17'(kernel_a);
  assign near0 = kin.t <= T_W'(256);
  assign t0s   = $signed({1'b0, kin.t});
  assign p0    = near0 ? a17 + 17'sd8192 : a17;
  assign q0    = near0 ? -((27'(a17) + 27'sd12288) <<< 8) : -((27'(a17) * 27'sd5) <<< 8);
  assign r1    = near1_r ? '0 : (S2_W'(kernel_a) <<< 19);
  assign c2    = near2_r ? (S3_W'(1) <<< 36) : -(S3_W'(kernel_a) <<< 26);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      kout_r.vld <= 1'b0;
    end else begin
      v1_r       <= kin.vld;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      kout_r.vld <= v3_r;
    end
    tag1_r  <= kin.tag;
    t1_r    <= kin.t;
    near1_r <= near0;
    s1_r    <= S1_W'(p0) * S1_W'(t0s) + S1_W'(q0);

    tag2_r  <= tag1_r;
    t2_r    <= t1_r;
    near2_r <= near1_r;
    s2_r    <= S2_W'(s1_r) * S2_W'($signed({1'b0, t1_r})) + r1;

    tag3_r  <= tag2_r;
    s3_r    <= S3_W'(s2_r) * S3_W'($signed({1'b0, t2_r})) + c2;

    kout_r.tag    <= tag3_r;
    kout_r.weight <= WT_W'((s3_r + (S3_W'(1) <<< 19)) >>> 20);
  end

  assign kout = kout_r;

endmodule

### hdl/tricubic_volume_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tricubic_volume_interpolator_top
// Voxel store with tricubic (Keys kernel) interpolation of point queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : items. cmd write stores voxel_value at voxel_index (no result).
//              cmd query interpolates at (coord_x, coord_y, coord_z).
//   out_chan : one result item per query: interp_value (Q16.8) and saturated.
//   cfg_chan : register writes, always ready; write only while idle.
// Sequence of a query: kernel weights (12 weights through a 4-stage unit),
//   64 voxel reads at one per cycle on the single memory port plus the
//   pipeline drain, the z sum, and a finish state that offers the result.
//   The block is then idle again and can take the next item in the cycle
//   the result is offered.
// in_chan.ready is high only while no query is in work. A finished result
//   waits in the output register; the block still takes items meanwhile and
//   holds a newer result back until out_chan takes the old one.
// Reset: registers go to their defaults, no result pending. Voxel contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module tricubic_volume_interpolator_top #(
  parameter int MAX_WIDTH  = tvi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tvi_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_DEPTH  = tvi_pkg::MAX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tvi_in_if.sink    in_chan,
  tvi_out_if.source out_chan,
  tvi_cfg_if.sink   cfg_chan
);
  import tvi_pkg::*;

  localparam int XIW   = $clog2(MAX_WIDTH);
  localparam int YIW   = $clog2(MAX_HEIGHT);
  localparam int ZIW   = $clog2(MAX_DEPTH);
  localparam int XDW   = $clog2(MAX_WIDTH + 1);
  localparam int YDW   = $clog2(MAX_HEIGHT + 1);
  localparam int STORE = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int AW    = $clog2(STORE);
  localparam int TW    = $clog2(MAX_HEIGHT * MAX_DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WGT  = 5'b00010,
    ST_GATH = 5'b00100,
    ST_ZSUM = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [DIMREG_W-1:0]    vol_w_r, vol_h_r, vol_d_r;
  logic signed [KA_W-1:0] ka_r;

  // query setup
  logic [IDX_FW-1:0]      ew, eh, ed;
  logic [IDX_FW-1:0]      xc [4];
  logic [IDX_FW-1:0]      yc [4];
  logic [IDX_FW-1:0]      zc [4];
  logic [7:0]             f_r [3];
  logic [XIW-1:0]         xi_r [4];
  logic [YIW-1:0]         yi_r [4];
  logic [ZIW-1:0]         zi_r [4];
  logic [XDW-1:0]         wd_r;
  logic [YDW-1:0]         hd_r;

  logic                   in_acc, wr_acc, q_acc, wr_hit;

  // weights
  logic [3:0]             wc_r;
  kin_t                   kin;
  kout_t                  kout;
  logic [7:0]             kf;
  logic signed [WT_W-1:0] wt_r [3][4];

  // gather pipeline
  logic [6:0]             gc_r;
  logic                   issue;
  logic [5:0]             n0;
  logic [ZIW+YDW-1:0]     zh;
  logic [TW+XDW-1:0]      xw;
  logic                   v1_r, v2_r, v3_r, v4_r, v6_r;
  logic [5:0]             n1_r, n2_r, n3_r, n4_r, n5_r, n6_r, n7_r;
  logic [TW-1:0]          t1_r;
  logic [AW-1:0]          addr_r, ram_addr;
  logic [VOX_W-1:0]       rdata;
  logic signed [PR_W-1:0] prod_r;
  logic signed [XS_W-1:0] xacc_r;
  logic                   xdone_r;
  logic signed [YP_W-1:0] ph_r, pl_r;
  logic signed [YS_W-1:0] yterm, ysum_r;
  logic                   ydone_r, pdone;
  logic signed [PL_W-1:0] plane_r [4];

  // z pass
  logic [2:0]             zs_r;
  logic                   z_issue, zv_r;
  logic signed [ZP_W-1:0] zph_r, zpl_r;
  logic signed [TS_W-1:0] tot_r;
  logic signed [RES_W-1:0] res;
  logic                   res_hi, res_lo;

  // output register
  logic                   out_valid_r, out_sat_r, out_load;
  logic signed [OUT_W-1:0] out_val_r;

  // ---------------- configuration ----------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_w_r <= DIM_RST;
      vol_h_r <= DIM_RST;
      vol_d_r <= DIM_RST;
      ka_r    <= KA_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_idx_t'(cfg_chan.index))
        CFG_VOL_WIDTH:  vol_w_r <= cfg_chan.data[DIMREG_W-1:0];
        CFG_VOL_HEIGHT: vol_h_r <= cfg_chan.data[DIMREG_W-1:0];
        CFG_VOL_DEPTH:  vol_d_r <= cfg_chan.data[DIMREG_W-1:0];
        CFG_KERNEL_A:   ka_r    <= $signed(cfg_chan.data[KA_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- accept ----------------
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign wr_acc = in_acc && (in_chan.cmd == CMD_WRITE);
  assign q_acc  = in_acc && (in_chan.cmd == CMD_QUERY);
  assign wr_hit = wr_acc && (32'(in_chan.voxel_index) < STORE);

  assign ew = eff_dim(vol_w_r, IDX_FW'(MAX_WIDTH));
  assign eh = eff_dim(vol_h_r, IDX_FW'(MAX_HEIGHT));
  assign ed = eff_dim(vol_d_r, IDX_FW'(MAX_DEPTH));

  // neighbor indices floor-1 .. floor+2, clamped to the bounds
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xc[i] = clamp_idx((IDX_FW+1)'($signed(in_chan.coord_x[CRD_W-1:8]))
                        + (IDX_FW+1)'(i - 1), ew - 1'b1);
      yc[i] = clamp_idx((IDX_FW+1)'($signed(in_chan.coord_y[CRD_W-1:8]))
                        + (IDX_FW+1)'(i - 1), eh - 1'b1);
      zc[i] = clamp_idx((IDX_FW+1)'($signed(in_chan.coord_z[CRD_W-1:8]))
                        + (IDX_FW+1)'(i - 1), ed - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_acc) begin
      f_r[0] <= in_chan.coord_x[7:0];
      f_r[1] <= in_chan.coord_y[7:0];
      f_r[2] <= in_chan.coord_z[7:0];
      wd_r   <= XDW'(ew);
      hd_r   <= YDW'(eh);
      for (int i = 0; i < 4; i++) begin
        xi_r[i] <= XIW'(xc[i]);
        yi_r[i] <= YIW'(yc[i]);
        zi_r[i] <= ZIW'(zc[i]);
      end
    end
  end

  // ---------------- kernel weights ----------------
  always_comb begin
    kf      = f_r[wc_r[3:2]];
    kin.vld = (state_r == ST_WGT) && (wc_r < 4'd12);
    kin.tag = wc_r;
    case (wc_r[1:0])
      2'd0:    kin.t = T_W'(256) + T_W'(kf);
      2'd1:    kin.t = T_W'(kf);
      2'd2:    kin.t = T_W'(256) - T_W'(kf);
      default: kin.t = T_W'(512) - T_W'(kf);
    endcase
  end

  tvi_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .kernel_a (ka_r),
    .kin      (kin),
    .kout     (kout)
  );

  always_ff @(posedge clk) begin
    if (kout.vld) begin
      wt_r[kout.tag[3:2]][kout.tag[1:0]] <= kout.weight;
    end
  end

  // ---------------- voxel memory ----------------
  assign ram_addr = wr_acc ? AW'(in_chan.voxel_index) : addr_r;

  tvi_ram #(
    .DATA_W (VOX_W),
    .DEPTH  (STORE)
  ) u_ram (
    .clk   (clk),
    .we    (wr_hit),
    .addr  (ram_addr),
    .wdata (in_chan.voxel_value),
    .rdata (rdata)
  );

  // ---------------- gather and x/y passes ----------------
  // item tag n = {k, j, i}: z row k, y row j, x tap i
  assign issue = (state_r == ST_GATH) && !gc_r[6];
  assign n0    = gc_r[5:0];
  assign zh    = zi_r[n0[5:4]] * hd_r;
  assign xw    = t1_r * wd_r;
  assign yterm = (YS_W'(ph_r) <<< 19) + YS_W'(pl_r);
  assign pdone = ydone_r && (n7_r[5:4] == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      xdone_r <= 1'b0;
      v6_r    <= 1'b0;
      ydone_r <= 1'b0;
    end else begin
      v1_r    <= issue;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      xdone_r <= v4_r && (n4_r[1:0] == 2'd3);
      v6_r    <= xdone_r;
      ydone_r <= v6_r && (n6_r[3:2] == 2'd3);
    end

    n1_r   <= n0;
    t1_r   <= TW'(zh + (ZIW+YDW)'(yi_r[n0[3:2]]));
    n2_r   <= n1_r;
    addr_r <= AW'(xw + (TW+XDW)'(xi_r[n1_r[1:0]]));
    n3_r   <= n2_r;
    n4_r   <= n3_r;
    prod_r <= PR_W'($signed(rdata)) * PR_W'(wt_r[0][n3_r[1:0]]);
    n5_r   <= n4_r;
    if (v4_r) begin
      xacc_r <= (n4_r[1:0] == 2'd0) ? XS_W'(prod_r) : xacc_r + XS_W'(prod_r);
    end
    // split the x sum so each product stays narrow
    n6_r <= n5_r;
    ph_r <= YP_W'($signed(xacc_r[XS_W-1:19])) * YP_W'(wt_r[1][n5_r[3:2]]);
    pl_r <= YP_W'($signed({1'b0, xacc_r[18:0]})) * YP_W'(wt_r[1][n5_r[3:2]]);
    n7_r <= n6_r;
    if (v6_r) begin
      ysum_r <= (n6_r[3:2] == 2'd0) ? yterm : ysum_r + yterm;
    end
    if (ydone_r) begin
      plane_r[n7_r[5:4]] <= PL_W'((ysum_r + (YS_W'(1) <<< 15)) >>> 16);
    end
  end

  // ---------------- z pass ----------------
  assign z_issue = (state_r == ST_ZSUM) && !zs_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zv_r <= 1'b0;
    end else begin
      zv_r <= z_issue;
    end
    zph_r <= ZP_W'($signed(plane_r[zs_r[1:0]][PL_W-1:20])) * ZP_W'(wt_r[2][zs_r[1:0]]);
    zpl_r <= ZP_W'($signed({1'b0, plane_r[zs_r[1:0]][19:0]})) * ZP_W'(wt_r[2][zs_r[1:0]]);
    if (pdone) begin
      tot_r <= '0;
    end else if (zv_r) begin
      tot_r <= tot_r + (TS_W'(zph_r) <<< 20) + TS_W'(zpl_r);
    end
  end

  assign res    = RES_W'((tot_r + (TS_W'(1) <<< 23)) >>> 24);
  assign res_hi = res > RES_W'(OUT_MAX);
  assign res_lo = res < RES_W'(OUT_MIN);

  // ---------------- sequencer ----------------
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_acc)               state_nxt = ST_WGT;
      ST_WGT:  if (wc_r == 4'd15)       state_nxt = ST_GATH;
      ST_GATH: if (pdone)               state_nxt = ST_ZSUM;
      ST_ZSUM: if (zs_r == 3'd5)        state_nxt = ST_FIN;
      ST_FIN:  if (out_load)            state_nxt = ST_IDLE;
      default:                          state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= '0;
      gc_r        <= '0;
      zs_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wc_r    <= (state_r == ST_WGT) ? wc_r + 1'b1 : '0;
      gc_r    <= (state_r == ST_GATH) ? gc_r + {6'd0, issue} : '0;
      zs_r    <= (state_r == ST_ZSUM) ? zs_r + 1'b1 : '0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sat_r <= res_hi || res_lo;
      out_val_r <= res_hi ? OUT_MAX : (res_lo ? OUT_MIN : OUT_W'(res));
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.interp_value = out_val_r;
  assign out_chan.saturated    = out_sat_r;

endmodule

### hdl/tvi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_cmd,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [tvi_pkg::OUT_W-1:0] out_value,
  input logic                             out_sat
);
  import tvi_pkg::*;

  `TVI_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result item dropped while stalled")
  `TVI_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_value) && $stable(out_sat), "stalled result item changed")
  `TVI_ASSERT(a_query_busy, clk, rst_n, in_valid && in_ready && in_cmd == CMD_QUERY |=> !in_ready, "item taken while a query is in work")
  `TVI_ASSERT(a_sat_clip, clk, rst_n, out_valid && out_sat |-> out_value == OUT_MAX || out_value == OUT_MIN, "saturated result not at a range limit")
  `TVI_ASSERT_NR(a_rst_clear, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind tricubic_volume_interpolator_top tvi_checker u_tvi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_cmd    (in_chan.cmd),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.interp_value),
  .out_sat   (out_chan.saturated)
);

### test/tvi_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvi_scoreboard
// Watches the item, result and register channels of the interpolator. It
// keeps its own voxel store and registers, computes the tricubic result of
// every accepted query, and compares the results in order.
// ----------------------------------------------------------------------------
module tvi_scoreboard (
  input  logic clk,
  input  logic rst_n,
  tvi_in_if    in_chan,
  tvi_out_if   out_chan,
  tvi_cfg_if   cfg_chan,
  output int   fail_count,
  output int   pending
);
  import tvi_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF * MAX_DEPTH_DEF;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    sat;
  } interp_result_t;

  logic signed [VOX_W-1:0] voxels [STORE_DEPTH];
  logic [DIMREG_W-1:0]     width_reg, height_reg, depth_reg;
  logic signed [KA_W-1:0]  kernel_reg;
  interp_result_t          expected_q [$];

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint bound_of(logic [DIMREG_W-1:0] r, longint mx);
    if (r == 0) begin
      return 1;
    end
    return (longint'(r) > mx) ? mx : longint'(r);
  endfunction

  function automatic longint clip(longint v, longint hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // Keys kernel, distance in Q8, a in Q12, weight rounded to Q16
  function automatic longint keys_weight(longint t, longint a);
    longint t2, t3, w;
    t2 = t * t;
    t3 = t2 * t;
    if (t <= 256) begin
      w = (a + 8192) * t3 - (a + 12288) * t2 * 256 + (longint'(1) <<< 36);
    end else if (t <= 512) begin
      w = a * t3 - 5 * a * t2 * 256 + 8 * a * t * 65536 - 4 * a * 16777216;
    end else begin
      w = 0;
    end
    return round_q(w, 20);
  endfunction

  function automatic interp_result_t interpolate(logic signed [CRD_W-1:0] cx,
                                                 logic signed [CRD_W-1:0] cy,
                                                 logic signed [CRD_W-1:0] cz);
    longint bw, bh, bd, a, f, xi, yi, zi, xsum, ysum, total, res;
    longint base [3];
    longint wt [3][4];
    longint plane [4];
    logic signed [CRD_W-1:0] c [3];
    interp_result_t r;
    bw = bound_of(width_reg, MAX_WIDTH_DEF);
    bh = bound_of(height_reg, MAX_HEIGHT_DEF);
    bd = bound_of(depth_reg, MAX_DEPTH_DEF);
    a = longint'(kernel_reg);
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    for (int ax = 0; ax < 3; ax++) begin
      base[ax] = longint'(c[ax]) >>> 8;
      f = longint'(c[ax]) - base[ax] * 256;
      wt[ax][0] = keys_weight(256 + f, a);
      wt[ax][1] = keys_weight(f, a);
      wt[ax][2] = keys_weight(256 - f, a);
      wt[ax][3] = keys_weight(512 - f, a);
    end
    for (int k = 0; k < 4; k++) begin
      zi = clip(base[2] - 1 + k, bd - 1);
      ysum = 0;
      for (int j = 0; j < 4; j++) begin
        yi = clip(base[1] - 1 + j, bh - 1);
        xsum = 0;
        for (int i = 0; i < 4; i++) begin
          xi = clip(base[0] - 1 + i, bw - 1);
          xsum += longint'(voxels[(zi * bh + yi) * bw + xi]) * wt[0][i];
        end
        ysum += xsum * wt[1][j];
      end
      plane[k] = round_q(ysum, 16);
    end
    total = 0;
    for (int k = 0; k < 4; k++) begin
      total += plane[k] * wt[2][k];
    end
    res = round_q(total, 24);
    r.sat = 1'b0;
    if (res > 8388607) begin
      res = 8388607;
      r.sat = 1'b1;
    end else if (res < -8388608) begin
      res = -8388608;
      r.sat = 1'b1;
    end
    r.value = OUT_W'(res);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    foreach (voxels[i]) voxels[i] = '0;
  end

  always @(posedge clk) begin
    interp_result_t got, want;
    if (!rst_n) begin
      width_reg  = DIM_RST;
      height_reg = DIM_RST;
      depth_reg  = DIM_RST;
      kernel_reg = KA_RST;
      expected_q.delete();
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_idx_t'(cfg_chan.index))
          CFG_VOL_WIDTH:  width_reg  = cfg_chan.data[DIMREG_W-1:0];
          CFG_VOL_HEIGHT: height_reg = cfg_chan.data[DIMREG_W-1:0];
          CFG_VOL_DEPTH:  depth_reg  = cfg_chan.data[DIMREG_W-1:0];
          CFG_KERNEL_A:   kernel_reg = cfg_chan.data[KA_W-1:0];
          default: ;
        endcase
      end
      if (out_chan.valid && out_chan.ready) begin
        got.value = out_chan.interp_value;
        got.sat   = out_chan.saturated;
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: interp_value %0d", got.value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("interp_value: expected %0d, got %0d", want.value, got.value);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, got.sat);
            fail_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (cmd_t'(in_chan.cmd) == CMD_WRITE) begin
          voxels[in_chan.voxel_index] = in_chan.voxel_value;
        end else begin
          expected_q.push_back(interpolate(in_chan.coord_x, in_chan.coord_y,
                                           in_chan.coord_z));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives voxel writes, queries and register writes into the tricubic
// interpolator through phases of different volume bounds and kernel
// parameters, with random idling on both sides; the scoreboard checks.
// ----------------------------------------------------------------------------
module testbench;
  import tvi_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   steady;        // no idling on either side
  bit   hold_request;  // receiver stalls for a long stretch
  int   bw, bh, bd;    // bounds in use

  tvi_in_if  in_if ();
  tvi_out_if out_if ();
  tvi_cfg_if cfg_if ();

  tricubic_volume_interpolator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  tvi_scoreboard checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_chan   (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tricubic_volume_interpolator_top verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int bound_of(int r);
    if (r == 0) begin
      return 1;
    end
    return (r > 32) ? 32 : r;
  endfunction

  // receiver side
  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        g = gap_len();
        if (g == 0) begin
          out_if.ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_if.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  task automatic send(cmd_t c, int idx, int val, int x, int y, int z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= c;
    in_if.voxel_index <= VIDX_W'(idx);
    in_if.voxel_value <= VOX_W'(val);
    in_if.coord_x     <= CRD_W'(x);
    in_if.coord_y     <= CRD_W'(y);
    in_if.coord_z     <= CRD_W'(z);
    do @(posedge clk); while (!in_if.ready);
  endtask

  // wait until every result is in, plus time for trailing writes
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DW'(value);
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic set_volume(int wr, int hr, int dr, int a);
    drain();
    write_reg(CFG_VOL_WIDTH, ($urandom_range(0, 511) << 6) | wr);
    write_reg(CFG_VOL_HEIGHT, ($urandom_range(0, 511) << 6) | hr);
    write_reg(CFG_VOL_DEPTH, ($urandom_range(0, 511) << 6) | dr);
    write_reg(CFG_KERNEL_A, a);
    cfg_if.valid <= 1'b0;
    bw = bound_of(wr);
    bh = bound_of(hr);
    bd = bound_of(dr);
  endtask

  // every voxel in bounds gets written before any query reads it
  task automatic fill_volume(bit extreme);
    int v;
    for (int i = 0; i < bw * bh * bd; i++) begin
      if (extreme) begin
        v = (((i % bw) + ((i / bw) % bh) + (i / (bw * bh))) % 2) ? -32768 : 32767;
      end else begin
        v = $urandom_range(0, 65535);
      end
      send(CMD_WRITE, i, v, $urandom, $urandom, $urandom);
    end
  endtask

  function automatic int pick_coord(int dim);
    if ($urandom_range(0, 99) < 85) begin
      return ($urandom_range(0, dim + 5) - 3) * 256 + $urandom_range(0, 255);
    end
    return $urandom_range(0, 32767);
  endfunction

  task automatic query(int x, int y, int z);
    send(CMD_QUERY, $urandom, $urandom, x, y, z);
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    steady = 1'b0;
    hold_request = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_WRITE;
    in_if.voxel_index = '0;
    in_if.voxel_value = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_VOL_WIDTH;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default kernel, small cube, coordinate extremes
    set_volume(4, 4, 4, -2048);
    steady = 1'b1;
    fill_volume(1'b0);
    query(0, 0, 0);
    query(-16384, -16384, -16384);
    query(16383, 16383, 16383);
    query(-16384, 16383, 128);
    query(-1, -1, -1);
    query(128, 128, 128);
    query(1, 255, 257);
    query(3 * 256 + 255, 2 * 256 + 128, 767);
    query(16383, -16384, 0);
    steady = 1'b0;

    // maximum |a| on a checkerboard of extreme samples: saturation
    set_volume(0, 5, 3, -16384);
    fill_volume(1'b1);
    query(128, 2 * 256 + 128, 256 + 128);
    query(-16384, 16383, -16384);
    query(0, 256 + 64, 384);
    query(200, 600, 500);

    // oversize width register, positive kernel parameter
    set_volume(63, 2, 1, 16383);
    fill_volume(1'b1);
    query(10 * 256 + 128, 128, 0);
    query(31 * 256 + 255, 16383, -5);
    query(-300, 300, 16383);

    set_volume(2, 32, 1, 0);
    fill_volume(1'b0);
    query(128, 16 * 256 + 77, 0);
    query(16383, 31 * 256, -16384);

    set_volume(1, 1, 32, -1024);
    fill_volume(1'b0);
    query(0, 0, 20 * 256 + 3);
    query(-16384, 0, 31 * 256 + 254);

    // random phases; the first opens with a long receiver hold-off
    for (int p = 0; p < 9; p++) begin
      set_volume($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 5),
                 (p % 3 == 2) ? $urandom_range(0, 32767) : -$urandom_range(0, 16384));
      steady = (p == 4);
      fill_volume(p == 6);
      if (p == 0) begin
        hold_request = 1'b1;
      end
      n = $urandom_range(100, 130);
      for (int q = 0; q < n; q++) begin
        if ($urandom_range(0, 9) == 0) begin
          send(CMD_WRITE, $urandom_range(0, 32767), $urandom_range(0, 65535),
               $urandom, $urandom, $urandom);
        end else begin
          query(pick_coord(bw), pick_coord(bh), pick_coord(bd));
        end
      end
      steady = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("tricubic_volume_interpolator_top verification clean");
    end else begin
      $display("tricubic_volume_interpolator_top verification failed");
    end
    $finish;
  end

endmodule
